>>> rtl/ile_pkg.sv
// Shared constants, codes and word types for the indexed list engine.
package ile_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int MODE_W     = 3;
  localparam int POS_W      = 5;
  localparam int STATUS_W   = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic [POS_W-1:0]             position;
    logic signed [VALUE_BITS-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] read_value;
    logic signed [VALUE_BITS-1:0] front_value;
    logic signed [VALUE_BITS-1:0] back_value;
    logic [LEN_W-1:0]             length_now;
    logic [STATUS_W-1:0]          status;
  } res_t;

endpackage

>>> rtl/ile_if.sv
// Valid/ready channel interfaces for command and result words.
interface ile_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [ile_pkg::MODE_W-1:0]             mode;
  logic [ile_pkg::POS_W-1:0]              position;
  logic signed [ile_pkg::VALUE_BITS-1:0]  item_value;

  modport source(output valid, mode, position, item_value, input ready);
  modport sink(input valid, mode, position, item_value, output ready);
endinterface

interface ile_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ile_pkg::VALUE_BITS-1:0]  read_value;
  logic signed [ile_pkg::VALUE_BITS-1:0]  front_value;
  logic signed [ile_pkg::VALUE_BITS-1:0]  back_value;
  logic [ile_pkg::LEN_W-1:0]              length_now;
  logic [ile_pkg::STATUS_W-1:0]           status;

  modport source(output valid, read_value, front_value, back_value, length_now, status,
                 input ready);
  modport sink(input valid, read_value, front_value, back_value, length_now, status,
               output ready);
endinterface

>>> rtl/ile_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module ile_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ile_ctrl.sv
// Command sequencer: read-modify-write passes over the cell RAM.
module ile_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  input  ile_pkg::cmd_t                         cmd,
  output logic                                  cmd_ready,
  output logic                                  res_valid,
  output ile_pkg::res_t                         res,
  input  logic                                  res_ready,
  output logic                                  ram_we,
  output logic [ile_pkg::IDX_W-1:0]             ram_waddr,
  output logic [ile_pkg::VALUE_BITS-1:0]        ram_wdata,
  output logic                                  ram_re,
  output logic [ile_pkg::IDX_W-1:0]             ram_raddr,
  input  logic [ile_pkg::VALUE_BITS-1:0]        ram_rdata
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECIDE   = 10'b00_0000_0010,
    S_LOOP_RD  = 10'b00_0000_0100,
    S_LOOP_WR  = 10'b00_0000_1000,
    S_READ_RD  = 10'b00_0001_0000,
    S_READ_CAP = 10'b00_0010_0000,
    S_FIN0     = 10'b00_0100_0000,
    S_FIN1     = 10'b00_1000_0000,
    S_FIN2     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    K_DOWN   = 3'b001,
    K_UP     = 3'b010,
    K_REMOVE = 3'b100
  } kind_t;

  localparam logic [ile_pkg::LEN_W-1:0] CAP_LEN = ile_pkg::LEN_W'(ile_pkg::CAPACITY);

  state_t                             state;
  kind_t                              kind;
  ile_pkg::cmd_t                      cmd_q;
  logic [ile_pkg::LEN_W-1:0]          len;
  logic [ile_pkg::LEN_W-1:0]          src;
  logic [ile_pkg::LEN_W-1:0]          dst;
  logic [ile_pkg::STATUS_W-1:0]       status;
  logic [ile_pkg::VALUE_BITS-1:0]     rd_val;
  logic [ile_pkg::VALUE_BITS-1:0]     front;
  logic [ile_pkg::VALUE_BITS-1:0]     back;

  logic [ile_pkg::LEN_W-1:0]          dst_dec;
  logic [ile_pkg::LEN_W-1:0]          len_dec;
  logic [ile_pkg::LEN_W-1:0]          pos_len;
  logic                               src_live;
  logic                               up_live;
  logic                               no_match;

  assign dst_dec  = dst - 1'b1;
  assign len_dec  = len - 1'b1;
  assign pos_len  = ile_pkg::LEN_W'(cmd_q.position);
  assign src_live = (src < len);
  assign up_live  = (dst > pos_len);
  assign no_match = (ram_rdata != ile_pkg::VALUE_BITS'(cmd_q.item_value));

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.read_value  = $signed(rd_val);
  assign res.front_value = $signed(front);
  assign res.back_value  = $signed(back);
  assign res.length_now  = len;
  assign res.status      = status;

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_DECIDE: begin
        if (cmd_q.mode == ile_pkg::MODE_APPEND && len != CAP_LEN) begin
          ram_we    = 1'b1;
          ram_waddr = len[ile_pkg::IDX_W-1:0];
          ram_wdata = ile_pkg::VALUE_BITS'(cmd_q.item_value);
        end
      end
      S_LOOP_RD: begin
        if (kind == K_UP) begin
          if (up_live) begin
            ram_re    = 1'b1;
            ram_raddr = dst_dec[ile_pkg::IDX_W-1:0];
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pos_len[ile_pkg::IDX_W-1:0];
            ram_wdata = ile_pkg::VALUE_BITS'(cmd_q.item_value);
          end
        end else if (src_live) begin
          ram_re    = 1'b1;
          ram_raddr = src[ile_pkg::IDX_W-1:0];
        end
      end
      S_LOOP_WR: begin
        ram_we    = (kind != K_REMOVE) || no_match;
        ram_waddr = dst[ile_pkg::IDX_W-1:0];
      end
      S_READ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_len[ile_pkg::IDX_W-1:0];
      end
      S_FIN0: begin
        ram_re    = (len != '0);
        ram_raddr = '0;
      end
      S_FIN1: begin
        ram_re    = 1'b1;
        ram_raddr = len_dec[ile_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q  <= cmd;
            status <= ile_pkg::ST_OK;
            rd_val <= '0;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_FIN0;
          case (cmd_q.mode)
            ile_pkg::MODE_APPEND: begin
              if (len == CAP_LEN) begin
                status <= ile_pkg::ST_FULL;
              end else begin
                len <= len + 1'b1;
              end
            end
            ile_pkg::MODE_POP: begin
              if (len == '0) begin
                status <= ile_pkg::ST_EMPTY;
              end else begin
                kind  <= K_DOWN;
                dst   <= '0;
                src   <= ile_pkg::LEN_W'(1);
                state <= S_LOOP_RD;
              end
            end
            ile_pkg::MODE_INSERT: begin
              if (len == CAP_LEN) begin
                status <= ile_pkg::ST_FULL;
              end else if (pos_len > len || cmd_q.position > ile_pkg::POS_W'(CAP_LEN)) begin
                status <= ile_pkg::ST_BADPOS;
              end else begin
                kind  <= K_UP;
                dst   <= len;
                state <= S_LOOP_RD;
              end
            end
            ile_pkg::MODE_ERASE: begin
              if (len == '0) begin
                status <= ile_pkg::ST_EMPTY;
              end else if (cmd_q.position >= ile_pkg::POS_W'(len)) begin
                status <= ile_pkg::ST_BADPOS;
              end else begin
                kind  <= K_DOWN;
                dst   <= pos_len;
                src   <= pos_len + 1'b1;
                state <= S_LOOP_RD;
              end
            end
            ile_pkg::MODE_REMOVE: begin
              kind  <= K_REMOVE;
              src   <= '0;
              dst   <= '0;
              state <= S_LOOP_RD;
            end
            ile_pkg::MODE_READ: begin
              if (len == '0) begin
                status <= ile_pkg::ST_EMPTY;
              end else if (cmd_q.position >= ile_pkg::POS_W'(len)) begin
                status <= ile_pkg::ST_BADPOS;
              end else begin
                state <= S_READ_RD;
              end
            end
            default: begin
            end
          endcase
        end
        S_LOOP_RD: begin
          case (kind)
            K_UP: begin
              if (up_live) begin
                state <= S_LOOP_WR;
              end else begin
                len   <= len + 1'b1;
                state <= S_FIN0;
              end
            end
            K_DOWN: begin
              if (src_live) begin
                state <= S_LOOP_WR;
              end else begin
                len   <= len_dec;
                state <= S_FIN0;
              end
            end
            default: begin
              if (src_live) begin
                state <= S_LOOP_WR;
              end else begin
                len   <= dst;
                state <= S_FIN0;
              end
            end
          endcase
        end
        S_LOOP_WR: begin
          case (kind)
            K_UP: begin
              dst <= dst_dec;
            end
            K_DOWN: begin
              src <= src + 1'b1;
              dst <= dst + 1'b1;
            end
            default: begin
              src <= src + 1'b1;
              if (no_match) begin
                dst <= dst + 1'b1;
              end
            end
          endcase
          state <= S_LOOP_RD;
        end
        S_READ_RD: begin
          state <= S_READ_CAP;
        end
        S_READ_CAP: begin
          rd_val <= ram_rdata;
          state  <= S_FIN0;
        end
        S_FIN0: begin
          if (len == '0) begin
            front <= '0;
            back  <= '0;
            state <= S_DONE;
          end else begin
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          front <= ram_rdata;
          state <= S_FIN2;
        end
        S_FIN2: begin
          back  <= ram_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/indexed_list_engine.sv
// Top level of the indexed list engine: sequencer, cell RAM and result register.
//
// An ordered list of up to CAPACITY signed values kept packed in a cell RAM
// (cell 0 is the front). Each command word on cmd (mode, position,
// item_value) appends, pops the front, inserts, erases, removes every equal
// entry, or reads at a position, and yields exactly one result word on res:
// read value, front and back values, new length and status.
//
// Both channels are valid/ready; a word moves on a clock edge with both high.
// Pop, insert, erase and remove pass over the entries they move or scan,
// reading each one and then writing it back. Any command that leaves the
// list empty skips the two front/back reads. The result sits in an output
// register, so cmd takes the next word while a finished result waits; a
// stalled receiver holds res and only the following result blocks in the
// sequencer.
//
// Reset (rst, synchronous) empties the list and drops any pending result.
// Cell contents are not cleared; only entries below the length are read.
module indexed_list_engine (
  input  logic      clk,
  input  logic      rst,
  ile_cmd_if.sink   cmd,
  ile_res_if.source res
);

  ile_pkg::cmd_t                      cmd_word;
  ile_pkg::res_t                      res_word;
  ile_pkg::res_t                      res_q;
  logic                               seq_res_valid;
  logic                               seq_res_ready;
  logic                               res_full;

  logic                               ram_we;
  logic [ile_pkg::IDX_W-1:0]          ram_waddr;
  logic [ile_pkg::VALUE_BITS-1:0]     ram_wdata;
  logic                               ram_re;
  logic [ile_pkg::IDX_W-1:0]          ram_raddr;
  logic [ile_pkg::VALUE_BITS-1:0]     ram_rdata;

  assign cmd_word.mode       = cmd.mode;
  assign cmd_word.position   = cmd.position;
  assign cmd_word.item_value = cmd.item_value;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd       (cmd_word),
    .cmd_ready (cmd.ready),
    .res_valid (seq_res_valid),
    .res       (res_word),
    .res_ready (seq_res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ile_ram #(
    .DEPTH (ile_pkg::CAPACITY),
    .WIDTH (ile_pkg::VALUE_BITS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign seq_res_ready = !res_full || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      res_full <= 1'b1;
      res_q    <= res_word;
    end else if (res.ready) begin
      res_full <= 1'b0;
    end
  end

  assign res.valid       = res_full;
  assign res.read_value  = res_q.read_value;
  assign res.front_value = res_q.front_value;
  assign res.back_value  = res_q.back_value;
  assign res.length_now  = res_q.length_now;
  assign res.status      = res_q.status;

endmodule

>>> tb/sv/tb_indexed_list_engine.sv
// Self-checking testbench for the indexed list engine: driver, monitor and list predictor.
`timescale 1ns / 100ps

module tb_indexed_list_engine;
  import ile_pkg::*;

  // Mode codes the block must treat as a no-op.
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int RANDOM_WORDS = 1125;
  localparam int DRAIN_CYCLES = 100;  // well past the slowest command

  logic clk = 1'b0;
  logic rst = 1'b1;

  ile_cmd_if cmd_ch ();
  ile_res_if res_ch ();

  indexed_list_engine i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // Command words waiting to be driven, and list snapshots the block owes us.
  cmd_t cmd_backlog[$];
  res_t list_snapshots[$];

  // Shadow copy of the list. Cells at or above shadow_len are never looked at.
  logic signed [VALUE_BITS-1:0] shadow_cells[CAPACITY];
  int                           shadow_len = 0;

  int   total_words    = 0;
  int   accepted_words = 0;
  logic cmd_taken      = 1'b0;
  logic failed         = 1'b0;

  // Idle percentages for sender and receiver. Three equal stretches by
  // accepted word count: sender light / receiver heavy, then swapped, then
  // both at full rate.
  int send_idle_pct;
  int recv_idle_pct;
  always_comb begin
    if (accepted_words * 3 < total_words) begin
      send_idle_pct = 38;
      recv_idle_pct = 63;
    end else if (accepted_words * 3 < total_words * 2) begin
      send_idle_pct = 63;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Apply one command to the shadow list and return the snapshot the block
  // should report. A failing command leaves the list untouched.
  function automatic res_t apply_list_cmd(cmd_t c);
    res_t snap;
    int   k;
    int   kept;
    int   pos;
    snap = '0;
    snap.status = ST_OK;
    pos = int'(c.position);
    case (c.mode)
      MODE_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          snap.status = ST_FULL;
        end else begin
          shadow_cells[shadow_len] = c.item_value;
          shadow_len++;
        end
      end
      MODE_POP: begin
        if (shadow_len == 0) begin
          snap.status = ST_EMPTY;
        end else begin
          for (k = 0; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      MODE_INSERT: begin
        // full wins over a bad position
        if (shadow_len >= CAPACITY) begin
          snap.status = ST_FULL;
        end else if (pos > shadow_len) begin
          snap.status = ST_BADPOS;
        end else begin
          for (k = shadow_len; k > pos; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[pos] = c.item_value;
          shadow_len++;
        end
      end
      MODE_ERASE: begin
        if (shadow_len == 0) begin
          snap.status = ST_EMPTY;
        end else if (pos >= shadow_len) begin
          snap.status = ST_BADPOS;
        end else begin
          for (k = pos; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      MODE_REMOVE: begin
        // order-preserving compaction; no match or empty list is still ok
        kept = 0;
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_cells[k] !== c.item_value) begin
            shadow_cells[kept] = shadow_cells[k];
            kept++;
          end
        end
        shadow_len = kept;
      end
      MODE_READ: begin
        if (shadow_len == 0) begin
          snap.status = ST_EMPTY;
        end else if (pos >= shadow_len) begin
          snap.status = ST_BADPOS;
        end else begin
          snap.read_value = shadow_cells[pos];
        end
      end
      default: ;  // spare modes: no change, ok
    endcase
    if (shadow_len > 0) begin
      snap.front_value = shadow_cells[0];
      snap.back_value  = shadow_cells[shadow_len-1];
    end
    snap.length_now = shadow_len[LEN_W-1:0];
    return snap;
  endfunction

  function automatic cmd_t list_cmd(logic [MODE_W-1:0] mode, int position,
                                    logic [VALUE_BITS-1:0] value);
    cmd_t c;
    c.mode       = mode;
    c.position   = position[POS_W-1:0];
    c.item_value = value;
    return c;
  endfunction

  task automatic report_field(string name, logic [VALUE_BITS-1:0] want,
                              logic [VALUE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: new command word at the falling edge once the previous one has
  // been taken (or none is up). valid gets at most one assignment per edge.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    cmd_t word;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        word = cmd_backlog.pop_front();
        cmd_ch.valid      <= 1'b1;
        cmd_ch.mode       <= word.mode;
        cmd_ch.position   <= word.position;
        cmd_ch.item_value <= word.item_value;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, also changed on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. The result check
  // runs before the new command is predicted; a result can never belong
  // to a command taken on the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.read_value  = res_ch.read_value;
        got.front_value = res_ch.front_value;
        got.back_value  = res_ch.back_value;
        got.length_now  = res_ch.length_now;
        got.status      = res_ch.status;
        if (list_snapshots.size() == 0) begin
          $display("%0t: result word with nothing expected: expected none, got 'h%0h",
                   $time, got);
          failed = 1'b1;
        end else begin
          want = list_snapshots.pop_front();
          report_field("read_value", want.read_value, got.read_value);
          report_field("front_value", want.front_value, got.front_value);
          report_field("back_value", want.back_value, got.back_value);
          report_field("length_now", VALUE_BITS'(want.length_now), VALUE_BITS'(got.length_now));
          report_field("status", VALUE_BITS'(want.status), VALUE_BITS'(got.status));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        list_snapshots.push_back(apply_list_cmd(list_cmd(cmd_ch.mode, int'(cmd_ch.position),
                                                         cmd_ch.item_value)));
        accepted_words++;
      end
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------
  initial begin
    logic signed [VALUE_BITS-1:0] value_pool[8];
    logic [VALUE_BITS-1:0]        value;
    logic [MODE_W-1:0]            mode;
    int                           pick;
    int                           position;
    int                           span;
    int                           n;
    bit                           growing;

    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = MODE_APPEND;
    cmd_ch.position   = '0;
    cmd_ch.item_value = '0;
    res_ch.ready      = 1'b0;

    // Directed: empty-list errors, value extremes, insert at front and at
    // length, out-of-range positions, multi-match remove, single-entry pop.
    cmd_backlog.push_back(list_cmd(MODE_POP,     0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_ERASE,   0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_READ,    0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_REMOVE,  0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_INSERT,  1, 32'h1234_5678));
    cmd_backlog.push_back(list_cmd(MODE_SPARE_6, 7, 32'hdead_beef));
    cmd_backlog.push_back(list_cmd(MODE_APPEND,  0, 32'h7fff_ffff));
    cmd_backlog.push_back(list_cmd(MODE_APPEND,  0, 32'h8000_0000));
    cmd_backlog.push_back(list_cmd(MODE_APPEND,  0, 32'h0000_0000));
    cmd_backlog.push_back(list_cmd(MODE_APPEND,  0, 32'hffff_ffff));
    cmd_backlog.push_back(list_cmd(MODE_INSERT,  0, 32'h5555_5555));
    cmd_backlog.push_back(list_cmd(MODE_INSERT,  5, 32'haaaa_aaaa));
    cmd_backlog.push_back(list_cmd(MODE_INSERT, 16, 32'h0000_0001));
    cmd_backlog.push_back(list_cmd(MODE_READ,    0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_READ,    5, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_READ,    6, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_READ,   16, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_ERASE,   5, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_ERASE,   0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_ERASE,   4, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_APPEND,  0, 32'hffff_ffff));
    cmd_backlog.push_back(list_cmd(MODE_REMOVE,  0, 32'hffff_ffff));
    cmd_backlog.push_back(list_cmd(MODE_REMOVE,  0, 32'd12345));
    cmd_backlog.push_back(list_cmd(MODE_SPARE_7, 31, 32'hffff_ffff));
    cmd_backlog.push_back(list_cmd(MODE_POP,     0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_POP,     0, 32'd0));
    cmd_backlog.push_back(list_cmd(MODE_POP,     0, 32'd0));

    // Random: a small pool of values so removes hit several entries at once.
    value_pool[0] = 32'sh7fff_ffff;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();

    // Alternate growing and shrinking runs so the list swings between empty
    // and full, with every position and the spare modes mixed in.
    n = 0;
    growing = 1'b1;
    while (n < RANDOM_WORDS) begin
      span = $urandom_range(60, 20);
      for (int i = 0; i < span && n < RANDOM_WORDS; i++) begin
        pick = $urandom_range(99, 0);
        if (growing) begin
          mode = (pick < 45) ? MODE_APPEND : (pick < 70) ? MODE_INSERT :
                 (pick < 77) ? MODE_POP    : (pick < 84) ? MODE_ERASE  :
                 (pick < 88) ? MODE_REMOVE : (pick < 98) ? MODE_READ   :
                 (pick < 99) ? MODE_SPARE_6 : MODE_SPARE_7;
        end else begin
          mode = (pick < 8)  ? MODE_APPEND : (pick < 15) ? MODE_INSERT :
                 (pick < 40) ? MODE_POP    : (pick < 65) ? MODE_ERASE  :
                 (pick < 80) ? MODE_REMOVE : (pick < 98) ? MODE_READ   :
                 (pick < 99) ? MODE_SPARE_6 : MODE_SPARE_7;
        end
        position = ($urandom_range(1, 0) != 0) ? $urandom_range(3, 0) : $urandom_range(16, 0);
        value = ($urandom_range(3, 0) != 0) ? value_pool[$urandom_range(7, 0)] : $urandom();
        cmd_backlog.push_back(list_cmd(mode, position, value));
        n++;
      end
      growing = !growing;
    end
    total_words = cmd_backlog.size();

    // Synchronous reset, released on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_words < total_words) @(posedge clk);
    while (list_snapshots.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (list_snapshots.size() > 0) begin
      $display("%0t: %0d result words never arrived", $time, list_snapshots.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: ends the run with a failure on timeout.
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/ile_pkg.sv
rtl/ile_if.sv
rtl/ile_ram.sv
rtl/ile_ctrl.sv
rtl/indexed_list_engine.sv
tb/sv/tb_indexed_list_engine.sv
